FILE: rtl/core/gpat_pkg.sv
// Shared types, register codes and constants for the game port axis timer.
package gpat_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int TIME_W          = 16;
  localparam int POS_W           = 32;
  localparam int SCALE_W         = 15;
  localparam int RANGE_W         = 16;
  localparam int QUO_W           = 31;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int IN_W            = 8;
  localparam int OUT_W           = 136;

  localparam logic [TIME_W-1:0]  TIME_MAX    = 16'hFFFF;
  localparam logic [15:0]        TIMEOUT_RST = 16'd4000;
  localparam logic [3:0]         MASK_FIRST  = 4'h3;
  localparam logic [3:0]         MASK_SECOND = 4'hC;
  localparam logic [1:0]         STICK_FIRST  = 2'd0;
  localparam logic [1:0]         STICK_SECOND = 2'd1;
  localparam logic [1:0]         STICK_OFF    = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STICK_SELECT   = 3'd0,
    REG_POTHEAD_ENABLE = 3'd1,
    REG_TIMEOUT_TICKS  = 3'd2,
    REG_CENTER_X       = 3'd3,
    REG_CENTER_Y       = 3'd4,
    REG_SCALE_FACTOR   = 3'd5,
    REG_RANGE_X        = 3'd6,
    REG_RANGE_Y        = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_DSTART = 6'b000100,
    S_DIV    = 6'b001000,
    S_OUT    = 6'b010000,
    S_SPARE  = 6'b100000
  } seq_state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: rtl/core/gpat_div.sv
// Restoring serial divider, one quotient bit per cycle.
module gpat_div
  import gpat_pkg::*;
#(
  parameter int NUM_W = QUO_W,
  parameter int DEN_W = RANGE_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output div_sts_t         sts,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/game_port_axis_timer.sv
// Game port axis timer: tick-driven axis timing with centred, scaled stick output.
// A start beat (tuser 0) arms a measurement from its port sample if the stick is
// enabled; each tick beat (tuser 1) advances the elapsed count and captures axes
// whose one-shot fell. A beat that does not end a measurement leaves in_tready high.
// A beat that ends one emits a single result beat after the X and Y positions are
// worked out: with scaling off (or the stick disabled) by the skip path, with scaling
// on through the 31-step serial divider shared by X and Y; in_tready stays low
// meanwhile and, if the previous result is still unread, until the output register
// frees. Configuration may be written only while no result is due.
module game_port_axis_timer
  import gpat_pkg::*;
#(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // [7:0] port_bits
  input  logic [0:0]           in_tuser,   // [0] operation
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [15:0] axis_time_1, [31:16] axis_time_2, [47:32] axis_time_3,
  // [63:48] axis_time_4, [95:64] pos_x, [127:96] pos_y,
  // [131:128] button_bits, [132] timed_out, [135:133] zero
  output logic [OUT_W-1:0]     out_tdata,
  // configuration
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW = (TIMER_WIDTH > TIME_W) ? TIMER_WIDTH : TIME_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

  // configuration registers
  logic [1:0]         stick_sel_r;
  logic               pothead_r;
  logic [15:0]        timeout_r;
  logic [15:0]        center_x_r, center_y_r;
  logic [SCALE_W-1:0] scale_r;
  logic [RANGE_W-1:0] range_x_r, range_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_sel_r <= STICK_FIRST;
      pothead_r   <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      center_x_r  <= '0;
      center_y_r  <= '0;
      scale_r     <= '0;
      range_x_r   <= RANGE_W'(1);
      range_y_r   <= RANGE_W'(1);
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_STICK_SELECT:   stick_sel_r <= cfg_wdata[1:0];
        REG_POTHEAD_ENABLE: pothead_r   <= cfg_wdata[0];
        REG_TIMEOUT_TICKS:  timeout_r   <= cfg_wdata[15:0];
        REG_CENTER_X:       center_x_r  <= cfg_wdata[15:0];
        REG_CENTER_Y:       center_y_r  <= cfg_wdata[15:0];
        REG_SCALE_FACTOR:   scale_r     <= cfg_wdata[SCALE_W-1:0];
        REG_RANGE_X:        range_x_r   <= cfg_wdata[RANGE_W-1:0];
        REG_RANGE_Y:        range_y_r   <= cfg_wdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  logic stick_on;
  assign stick_on = (stick_sel_r == STICK_FIRST) || (stick_sel_r == STICK_SECOND);

  // measurement state
  logic [TIMER_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [3:0]             pending_r, pending_nxt;
  logic [7:0]             last_r, last_nxt;
  logic [TIME_W-1:0]      capt_r [4];
  logic [TIME_W-1:0]      capt_nxt [4];
  logic                   measuring_r, measuring_nxt;
  logic                   timed_out_r, timed_out_nxt;

  seq_state_t             state_r, state_nxt;

  logic                   in_acc;
  logic                   fin;
  logic                   fin_to;
  logic [3:0]             sel;
  logic [3:0]             fell;
  logic [TIMER_WIDTH-1:0] el_inc;
  logic [CW-1:0]          el_ext;
  logic [TIME_W-1:0]      el_clamp;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign el_inc   = (elapsed_r != TMAX) ? elapsed_r + 1'b1 : elapsed_r;
  assign el_ext   = CW'(el_inc);
  assign el_clamp = (el_ext > CW'(TIME_MAX)) ? TIME_MAX : el_ext[TIME_W-1:0];

  always_comb begin
    elapsed_nxt   = elapsed_r;
    pending_nxt   = pending_r;
    last_nxt      = last_r;
    measuring_nxt = measuring_r;
    timed_out_nxt = timed_out_r;
    for (int i = 0; i < 4; i++) capt_nxt[i] = capt_r[i];
    fin    = 1'b0;
    fin_to = 1'b0;
    sel    = (stick_sel_r == STICK_FIRST) ? MASK_FIRST : MASK_SECOND;
    if (pothead_r) sel = sel | MASK_SECOND;
    fell   = pending_r & ~in_tdata[3:0];

    if (in_acc) begin
      if (op_t'(in_tuser[0]) == OP_START) begin
        // a disabled stick ignores the start and leaves any run going
        if (stick_on) begin
          elapsed_nxt   = '0;
          for (int i = 0; i < 4; i++) capt_nxt[i] = '0;
          last_nxt      = in_tdata;
          pending_nxt   = in_tdata[3:0] & sel;
          measuring_nxt = 1'b1;
          if (pending_nxt == 4'h0) fin = 1'b1;
        end
      end else if (measuring_r) begin
        elapsed_nxt = el_inc;
        last_nxt    = in_tdata;
        for (int i = 0; i < 4; i++) begin
          if (fell[i]) capt_nxt[i] = el_clamp;
        end
        pending_nxt = pending_r & in_tdata[3:0];
        if (pending_nxt == 4'h0) begin
          fin = 1'b1;
        end else if ((el_ext >= CW'(timeout_r)) || (el_inc == TMAX)) begin
          fin    = 1'b1;
          fin_to = 1'b1;
        end
      end
    end

    if (fin) begin
      measuring_nxt = 1'b0;
      pending_nxt   = 4'h0;
      timed_out_nxt = fin_to;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      pending_r   <= '0;
      last_r      <= '0;
      measuring_r <= 1'b0;
      timed_out_r <= 1'b0;
      for (int i = 0; i < 4; i++) capt_r[i] <= '0;
    end else begin
      elapsed_r   <= elapsed_nxt;
      pending_r   <= pending_nxt;
      last_r      <= last_nxt;
      measuring_r <= measuring_nxt;
      timed_out_r <= timed_out_nxt;
      for (int i = 0; i < 4; i++) capt_r[i] <= capt_nxt[i];
    end
  end

  // position sequencer: one multiply, then the shared divider, per axis unless scaling is off or the stick disabled
  logic                     axis_r, axis_nxt;
  logic signed [POS_W-1:0]  prod_r, prod_nxt;
  logic [POS_W-1:0]         res_x_r, res_x_nxt;
  logic [POS_W-1:0]         res_y_r, res_y_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]         out_data_r, out_data_nxt;

  logic [TIME_W-1:0]        t_sel;
  logic [15:0]              centre;
  logic [RANGE_W-1:0]       range_sel;
  logic signed [16:0]       v;
  logic signed [32:0]       prod_full;
  logic                     skip;
  logic [POS_W-1:0]         skip_val;
  logic                     neg;
  logic [POS_W-1:0]         mag;
  logic [POS_W-1:0]         div_res;
  logic [3:0]               btn;

  div_ctl_t                 dctl;
  div_sts_t                 dsts;
  logic [QUO_W-1:0]         quo;

  always_comb begin
    if (stick_sel_r == STICK_SECOND) t_sel = axis_r ? capt_r[3] : capt_r[2];
    else                             t_sel = axis_r ? capt_r[1] : capt_r[0];
    centre    = axis_r ? center_y_r : center_x_r;
    range_sel = axis_r ? range_y_r : range_x_r;
    if (range_sel == '0) range_sel = RANGE_W'(1);
    v         = $signed({1'b0, t_sel}) - $signed({1'b0, centre});
    prod_full = v * $signed({1'b0, scale_r});
    skip      = !stick_on || (scale_r == '0);
    skip_val  = stick_on ? {{(POS_W-17){v[16]}}, v} : '0;
    neg       = prod_r[POS_W-1];
    mag       = neg ? POS_W'(-prod_r) : POS_W'(prod_r);
    div_res   = neg ? POS_W'(-{1'b0, quo}) : {1'b0, quo};
    btn       = ~last_r[7:4];
    if (stick_sel_r == STICK_SECOND) btn = btn >> 2;
  end

  assign dctl.start = (state_r == S_DSTART);

  gpat_div #(
    .NUM_W (QUO_W),
    .DEN_W (RANGE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dctl),
    .dividend (mag[QUO_W-1:0]),
    .divisor  (range_sel),
    .sts      (dsts),
    .quotient (quo)
  );

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    prod_nxt      = prod_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (fin) begin
          axis_nxt  = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (skip) begin
          if (axis_r) begin
            res_y_nxt = skip_val;
            state_nxt = S_OUT;
          end else begin
            res_x_nxt = skip_val;
            axis_nxt  = 1'b1;
          end
        end else begin
          prod_nxt  = prod_full[POS_W-1:0];
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: state_nxt = S_DIV;
      S_DIV: begin
        if (dsts.done) begin
          if (axis_r) begin
            res_y_nxt = div_res;
            state_nxt = S_OUT;
          end else begin
            res_x_nxt = div_res;
            axis_nxt  = 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_OUT: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, timed_out_r, btn, res_y_r, res_x_r,
                           capt_r[3], capt_r[2], capt_r[1], capt_r[0]};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_pending_measuring: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r != 4'h0) |-> measuring_r)
    else $error("pending axes while not measuring");

  a_finish_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> (state_r == S_MUL) && (axis_r == 1'b0))
    else $error("finished measurement did not start the position sequence");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    dsts.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && out_valid_r && !out_tready) |=> (state_r == S_OUT))
    else $error("result dropped while output register was full");

endmodule

FILE: verif/tb_game_port_axis_timer.sv
// Self-checking testbench for the game port axis timer: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module tb_game_port_axis_timer;
  import gpat_pkg::*;

  // Result beat as laid out on out_tdata, lowest field last.
  typedef struct packed {
    logic [2:0]  pad;
    logic        timed_out;
    logic [3:0]  buttons;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [15:0] time4;
    logic [15:0] time3;
    logic [15:0] time2;
    logic [15:0] time1;
  } stick_reading_t;

  typedef struct {
    op_t        op;
    logic [7:0] bits;
  } port_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;   // [7:0] port_bits
  logic [0:0]           in_tuser = '0;   // [0] operation
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [15:0] axis_time_1, [31:16] axis_time_2, [47:32] axis_time_3,
  // [63:48] axis_time_4, [95:64] pos_x, [127:96] pos_y,
  // [131:128] button_bits, [132] timed_out, [135:133] zero
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  game_port_axis_timer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers and the measurement state
  logic [1:0]  gp_stick = STICK_FIRST;
  logic        gp_pothead = 1'b0;
  logic [15:0] gp_timeout = TIMEOUT_RST;
  logic [15:0] gp_center_x = '0;
  logic [15:0] gp_center_y = '0;
  logic [14:0] gp_scale = '0;
  logic [15:0] gp_range_x = 16'd1;
  logic [15:0] gp_range_y = 16'd1;

  logic [15:0] elapsed = '0;
  logic [3:0]  pending = '0;
  logic [7:0]  last_port = '0;
  logic [15:0] cap_time [4] = '{default: '0};
  logic        measuring = 1'b0;

  port_beat_t     beat_q [$];
  stick_reading_t reading_q [$];
  stick_reading_t got_reading, want_reading;

  bit in_fired = 1'b0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int mismatches = 0;
  int beats_used = 0;
  int beats_ignored = 0;
  int results_seen = 0;
  int timeouts_seen = 0;
  int phases = 0;
  int k;

  function automatic logic [31:0] stick_offset(input logic [15:0] t, input logic [15:0] centre,
                                               input logic [15:0] span);
    longint v, d;
    v = longint'({48'd0, t}) - longint'({48'd0, centre});
    if (gp_scale != 0) begin
      d = (span == 0) ? 64'sd1 : longint'({48'd0, span});
      v = (v * longint'({49'd0, gp_scale})) / d;  // truncates toward zero
    end
    return v[31:0];
  endfunction

  function automatic void close_measurement(input logic hit_timeout);
    stick_reading_t r;
    logic [3:0] btn;
    r = '0;
    btn = ~last_port[7:4];
    r.time1 = cap_time[0];
    r.time2 = cap_time[1];
    r.time3 = cap_time[2];
    r.time4 = cap_time[3];
    if (gp_stick == STICK_FIRST) begin
      r.pos_x = stick_offset(cap_time[0], gp_center_x, gp_range_x);
      r.pos_y = stick_offset(cap_time[1], gp_center_y, gp_range_y);
    end else if (gp_stick == STICK_SECOND) begin
      r.pos_x = stick_offset(cap_time[2], gp_center_x, gp_range_x);
      r.pos_y = stick_offset(cap_time[3], gp_center_y, gp_range_y);
      btn = btn >> 2;
    end
    r.buttons = btn;
    r.timed_out = hit_timeout;
    reading_q.push_back(r);
    measuring = 1'b0;
    pending = '0;
  endfunction

  function automatic void predict_beat(input op_t op, input logic [7:0] bits);
    logic [3:0] sel, fell;
    if (op == OP_START) begin
      if (gp_stick > STICK_SECOND) begin
        beats_ignored++;
        return;
      end
      beats_used++;
      sel = (gp_stick == STICK_FIRST) ? MASK_FIRST : MASK_SECOND;
      if (gp_pothead) sel |= MASK_SECOND;
      elapsed = '0;
      foreach (cap_time[i]) cap_time[i] = '0;
      last_port = bits;
      pending = bits[3:0] & sel;
      measuring = 1'b1;
      if (pending == 0) close_measurement(1'b0);
    end else if (!measuring) begin
      beats_ignored++;
    end else begin
      beats_used++;
      if (elapsed != TIME_MAX) elapsed++;
      last_port = bits;
      fell = pending & ~bits[3:0];
      foreach (cap_time[i]) if (fell[i]) cap_time[i] = elapsed;
      pending &= bits[3:0];
      if (pending == 0) close_measurement(1'b0);
      else if (elapsed >= gp_timeout || elapsed == TIME_MAX) close_measurement(1'b1);
    end
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: check result beats first, then feed the accepted input beat to the predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_reading = out_tdata;
        results_seen++;
        if (got_reading.timed_out) timeouts_seen++;
        if (reading_q.size() == 0) begin
          $display("%0t: result expected none, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want_reading = reading_q.pop_front();
          compare_field("axis_time_1", 32'(want_reading.time1), 32'(got_reading.time1));
          compare_field("axis_time_2", 32'(want_reading.time2), 32'(got_reading.time2));
          compare_field("axis_time_3", 32'(want_reading.time3), 32'(got_reading.time3));
          compare_field("axis_time_4", 32'(want_reading.time4), 32'(got_reading.time4));
          compare_field("pos_x", want_reading.pos_x, got_reading.pos_x);
          compare_field("pos_y", want_reading.pos_y, got_reading.pos_y);
          compare_field("button_bits", 32'(want_reading.buttons), 32'(got_reading.buttons));
          compare_field("timed_out", 32'(want_reading.timed_out), 32'(got_reading.timed_out));
          compare_field("pad", 32'(want_reading.pad), 32'(got_reading.pad));
        end
      end
      in_fired = in_tvalid && in_tready;
      if (in_fired) predict_beat(op_t'(in_tuser[0]), in_tdata);
    end
  end

  // Driver: advance to the next queued beat once the current one is taken
  always @(negedge clk) begin
    port_beat_t nxt;
    if (rst_n && (!in_tvalid || in_fired)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (beat_q.size() != 0) begin
        nxt = beat_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.op;
        in_tdata <= nxt.bits;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 17);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_left = 300;
      hold_taken = 1'b1;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
    end
  end

  task automatic push_beat(input op_t op, input logic [7:0] bits);
    port_beat_t b;
    b.op = op;
    b.bits = bits;
    beat_q.push_back(b);
  endtask

  // Return once every queued beat is taken and every result is in, then settle
  task automatic wait_quiet(input int settle);
    do begin
      @(posedge clk);
      #1;
    end while (!(beat_q.size() == 0 && (!in_tvalid || in_fired) && reading_q.size() == 0));
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_STICK_SELECT:   gp_stick = val[1:0];
      REG_POTHEAD_ENABLE: gp_pothead = val[0];
      REG_TIMEOUT_TICKS:  gp_timeout = val;
      REG_CENTER_X:       gp_center_x = val;
      REG_CENTER_Y:       gp_center_y = val;
      REG_SCALE_FACTOR:   gp_scale = val[14:0];
      REG_RANGE_X:        gp_range_x = val;
      REG_RANGE_Y:        gp_range_y = val;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] wide_value();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 60));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic pick_settings();
    logic [15:0] tmo;
    case ($urandom_range(0, 7))
      0: tmo = 16'd0;
      1: tmo = 16'hFFFF;
      2: tmo = TIMEOUT_RST;
      default: tmo = 16'($urandom_range(1, 40));
    endcase
    // junk above the register width must be dropped
    cfg_write(REG_STICK_SELECT, {14'($urandom), ($urandom_range(0, 5) == 0) ?
                                 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1))});
    cfg_write(REG_POTHEAD_ENABLE, 16'($urandom));
    cfg_write(REG_TIMEOUT_TICKS, tmo);
    cfg_write(REG_CENTER_X, wide_value());
    cfg_write(REG_CENTER_Y, wide_value());
    case ($urandom_range(0, 5))
      0, 1: cfg_write(REG_SCALE_FACTOR, {1'($urandom), 15'd0});
      2: cfg_write(REG_SCALE_FACTOR, 16'h7FFF);
      3: cfg_write(REG_SCALE_FACTOR, 16'd1);
      default: cfg_write(REG_SCALE_FACTOR, 16'($urandom));
    endcase
    cfg_write(REG_RANGE_X, wide_value());
    cfg_write(REG_RANGE_Y, wide_value());
    @(negedge clk) cfg_wen <= 1'b0;
  endtask

  // One start plus ticks in which each high axis falls at a random count
  task automatic queue_measurement(input bit cut_short);
    logic [7:0] smp;
    int fall [4];
    int lim, n, t;
    lim = (gp_timeout < 48) ? gp_timeout + 2 : 48;
    smp = 8'($urandom);
    n = 0;
    for (int i = 0; i < 4; i++) begin
      smp[i] = ($urandom_range(0, 7) != 0);
      fall[i] = $urandom_range(1, lim);
      if (smp[i] && fall[i] > n) n = fall[i];
    end
    if (cut_short) n = $urandom_range(0, n);
    push_beat(OP_START, smp);
    for (t = 1; t <= n; t++) begin
      smp[7:4] = 4'($urandom);
      for (int i = 0; i < 4; i++) smp[i] = (t < fall[i]) ? 1'b1 : ($urandom_range(0, 9) == 0);
      push_beat(OP_TICK, smp);
    end
  endtask

  task automatic run_phase(input int n_seq);
    // leading ticks carry on a measurement left over from the last setting
    repeat ($urandom_range(0, 3)) push_beat(OP_TICK, 8'($urandom));
    for (int s = 0; s < n_seq; s++) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 3)) push_beat(op_t'($urandom_range(0, 1)), 8'($urandom));
        1: queue_measurement(1'b1);
        default: queue_measurement(1'b0);
      endcase
    end
    if ($urandom_range(0, 2) == 0) queue_measurement(1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset settings: plain capture, idle tick, nothing high, restart
    push_beat(OP_START, 8'hFF);
    push_beat(OP_TICK, 8'hFE);
    push_beat(OP_TICK, 8'h00);
    push_beat(OP_TICK, 8'h55);
    push_beat(OP_START, 8'hF0);
    push_beat(OP_START, 8'h0F);
    push_beat(OP_TICK, 8'h0F);
    push_beat(OP_START, 8'h03);
    push_beat(OP_TICK, 8'h00);
    wait_quiet(10);

    // second stick with head tracker, zero timeout, extreme centre/scale/range
    cfg_write(REG_STICK_SELECT, 16'(STICK_SECOND));
    cfg_write(REG_POTHEAD_ENABLE, 16'd1);
    cfg_write(REG_TIMEOUT_TICKS, 16'd0);
    cfg_write(REG_CENTER_X, 16'hFFFF);
    cfg_write(REG_CENTER_Y, 16'd0);
    cfg_write(REG_SCALE_FACTOR, 16'h7FFF);
    cfg_write(REG_RANGE_X, 16'd0);
    cfg_write(REG_RANGE_Y, 16'hFFFF);
    @(negedge clk) cfg_wen <= 1'b0;
    push_beat(OP_START, 8'h0F);
    push_beat(OP_TICK, 8'h0A);
    push_beat(OP_START, 8'h0F);
    push_beat(OP_TICK, 8'h00);
    wait_quiet(10);

    // disable the stick while a measurement runs
    cfg_write(REG_STICK_SELECT, 16'(STICK_FIRST));
    cfg_write(REG_POTHEAD_ENABLE, 16'd0);
    cfg_write(REG_TIMEOUT_TICKS, 16'hFFFF);
    cfg_write(REG_SCALE_FACTOR, 16'd0);
    @(negedge clk) cfg_wen <= 1'b0;
    push_beat(OP_START, 8'h03);
    push_beat(OP_TICK, 8'h01);
    wait_quiet(10);
    cfg_write(REG_STICK_SELECT, 16'(STICK_OFF));
    @(negedge clk) cfg_wen <= 1'b0;
    push_beat(OP_START, 8'hFF);
    push_beat(OP_TICK, 8'h00);
    wait_quiet(10);

    // hold the output long enough that the input backs up
    cfg_write(REG_STICK_SELECT, 16'(STICK_FIRST));
    cfg_write(REG_SCALE_FACTOR, 16'd12345);
    cfg_write(REG_RANGE_X, 16'd77);
    @(negedge clk) cfg_wen <= 1'b0;
    hold_request = 1'b1;
    repeat (24) push_beat(OP_START, {4'($urandom), 4'h0});
    wait_quiet(10);

    while (beats_used < 480) begin
      phases++;
      pick_settings();
      idle_on = ($urandom_range(0, 3) != 0);
      run_phase($urandom_range(4, 12));
      wait_quiet(10);
    end

    // no idling from here: timeout with axis 2 falling on the last tick
    idle_on = 1'b0;
    cfg_write(REG_STICK_SELECT, 16'(STICK_FIRST));
    cfg_write(REG_POTHEAD_ENABLE, 16'd1);
    cfg_write(REG_TIMEOUT_TICKS, 16'd20);
    cfg_write(REG_CENTER_X, 16'hFFFF);
    cfg_write(REG_CENTER_Y, 16'd0);
    cfg_write(REG_SCALE_FACTOR, 16'h7FFF);
    cfg_write(REG_RANGE_X, 16'd1);
    cfg_write(REG_RANGE_Y, 16'd1);
    @(negedge clk) cfg_wen <= 1'b0;
    push_beat(OP_START, 8'h0F);
    for (k = 1; k < 20; k++) push_beat(OP_TICK, 8'h03);
    push_beat(OP_TICK, 8'h11);
    wait_quiet(10);

    pick_settings();
    run_phase(6);
    wait_quiet(100);

    $display("Run covered %0d counted beats, %0d ignored, over %0d random settings.",
             beats_used, beats_ignored, phases);
    $display("Checked %0d result beats, %0d of them ended by timeout.",
             results_seen, timeouts_seen);
    if (mismatches == 0 && reading_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d results still due", reading_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/gpat_pkg.sv
rtl/core/gpat_div.sv
rtl/core/game_port_axis_timer.sv
verif/tb_game_port_axis_timer.sv
